/* rtl/srsp_pkg.sv */
// Shared types, codes and the silencing write table of the register stream player.
package srsp_pkg;

	localparam int SIL_LEN = 36;
	localparam int SIL_IDX_W = $clog2(SIL_LEN);
	localparam int WAIT_W = 33;
	localparam int OFF_W = 32;
	localparam int OUT_DATA_W = 88;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;
	localparam logic [1:0] CMD_STOP  = 2'd3;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_WRITE   = 3'd1;
	localparam logic [2:0] EV_WAIT    = 3'd2;
	localparam logic [2:0] EV_LOOP    = 3'd3;
	localparam logic [2:0] EV_STOPPED = 3'd4;
	localparam logic [2:0] EV_BAD     = 3'd5;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] stream_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        event_res;
		logic [7:0]        reg_addr;
		logic [7:0]        reg_data;
		logic [WAIT_W-1:0] wait_cycles;
		logic [OFF_W-1:0]  play_offset;
		logic              want_byte;
		logic              last_of_run;
	} result_t;

	function automatic logic [7:0] silence_addr(input logic [SIL_IDX_W-1:0] idx);
		logic [7:0] a;
		case (idx)
			6'd0:  a = 8'h84;
			6'd1:  a = 8'h60;
			6'd2:  a = 8'h62;
			6'd3:  a = 8'h63;
			6'd4:  a = 8'h64;
			6'd5:  a = 8'h65;
			6'd6:  a = 8'h68;
			6'd7:  a = 8'h69;
			6'd8:  a = 8'h6c;
			6'd9:  a = 8'h6d;
			6'd10: a = 8'h90;
			6'd11: a = 8'h91;
			6'd12: a = 8'h92;
			6'd13: a = 8'h93;
			6'd14: a = 8'h94;
			6'd15: a = 8'h95;
			6'd16: a = 8'h96;
			6'd17: a = 8'h97;
			6'd18: a = 8'h98;
			6'd19: a = 8'h99;
			6'd20: a = 8'h9a;
			6'd21: a = 8'h9b;
			6'd22: a = 8'h9c;
			6'd23: a = 8'h9d;
			6'd24: a = 8'h9e;
			6'd25: a = 8'h9f;
			6'd26: a = 8'h70;
			6'd27: a = 8'h72;
			6'd28: a = 8'h74;
			6'd29: a = 8'h78;
			6'd30: a = 8'h79;
			6'd31: a = 8'h7c;
			6'd32: a = 8'h7d;
			6'd33: a = 8'h80;
			6'd34: a = 8'h81;
			6'd35: a = 8'h84;
			default: a = 8'h00;
		endcase
		return a;
	endfunction

	function automatic logic [7:0] silence_data(input logic [SIL_IDX_W-1:0] idx);
		logic [7:0] d;
		case (idx)
			6'd28: d = 8'h80;
			6'd33: d = 8'h77;
			6'd34: d = 8'hff;
			6'd35: d = 8'h80;
			default: d = 8'h00;
		endcase
		return d;
	endfunction

endpackage

/* rtl/srsp_in_stage.sv */
// Input register stage holding one accepted command transaction.
module srsp_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic [1:0]        s_tuser,
	input  logic              consume,
	output logic              item_valid,
	output srsp_pkg::in_item_t item
);
	import srsp_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;

	assign s_tready   = !valid_s1 || consume;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.command     <= s_tuser;
			item_s1.stream_byte <= s_tdata;
		end
	end

endmodule

/* rtl/srsp_engine.sv */
// Player state, stream parser and silencing run sequencer.
module srsp_engine #(
	parameter logic [7:0] OP_WRITE_REG = 8'd1,
	parameter logic [7:0] OP_WAIT      = 8'd2,
	parameter logic [7:0] OP_END       = 8'd3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               loop_enable,
	input  logic               item_valid,
	input  srsp_pkg::in_item_t item,
	input  logic               slot_free,
	output logic               emit,
	output logic               consume,
	output srsp_pkg::result_t  res
);
	import srsp_pkg::*;

	localparam logic [2:0] M_STOPPED   = 3'd0;
	localparam logic [2:0] M_WAITING   = 3'd1;
	localparam logic [2:0] M_OPCODE    = 3'd2;
	localparam logic [2:0] M_ADDR      = 3'd3;
	localparam logic [2:0] M_DATA      = 3'd4;
	localparam logic [2:0] M_WAITBYTES = 3'd5;
	localparam logic [2:0] M_LOOPBYTES = 3'd6;
	localparam logic [2:0] M_ERROR     = 3'd7;

	logic [2:0]           mode_q, mode_n;
	logic [1:0]           fcnt_q, fcnt_n;
	logic [7:0]           haddr_q, haddr_n;
	logic [31:0]          asm_q, asm_n, asm_or;
	logic [WAIT_W-1:0]    wait_q, wait_n, wait_dec;
	logic [OFF_W-1:0]     off_q, off_n;
	logic                 run_q;
	logic [SIL_IDX_W-1:0] cnt_q;
	logic                 is_sil;
	logic                 sil_last;
	logic [16:0]          lo_part;
	logic [15:0]          hi_part;

	assign emit     = item_valid && slot_free;
	assign sil_last = (cnt_q == SIL_IDX_W'(SIL_LEN - 1));
	assign consume  = emit && (run_q ? sil_last : !is_sil);
	assign wait_dec = wait_q - WAIT_W'(wait_q != '0);
	assign asm_or   = asm_q | (32'(item.stream_byte) << {fcnt_q, 3'b000});
	assign lo_part  = 17'h10000 - 17'(asm_or[15:0]);
	assign hi_part  = 16'hffff - asm_or[31:16];

	always_comb begin
		mode_n  = mode_q;
		fcnt_n  = fcnt_q;
		haddr_n = haddr_q;
		asm_n   = asm_q;
		wait_n  = wait_q;
		off_n   = off_q;
		is_sil  = 1'b0;
		res     = '0;
		res.last_of_run = 1'b1;
		if (run_q) begin
			res.event_res   = EV_WRITE;
			res.reg_addr    = silence_addr(cnt_q);
			res.reg_data    = silence_data(cnt_q);
			res.last_of_run = sil_last;
		end else begin
			case (item.command)
				CMD_START: begin
					fcnt_n  = '0;
					haddr_n = '0;
					asm_n   = '0;
					off_n   = '0;
					wait_n  = WAIT_W'(1);
					mode_n  = M_WAITING;
					is_sil  = 1'b1;
				end
				CMD_STOP: begin
					mode_n = M_STOPPED;
					is_sil = 1'b1;
				end
				default: begin
					if (mode_q == M_STOPPED) begin
						res.event_res = EV_STOPPED;
					end else if (mode_q == M_ERROR) begin
						res.event_res = EV_BAD;
					end else if (item.command == CMD_TICK) begin
						if (mode_q == M_WAITING) begin
							wait_n = wait_dec;
							if (wait_dec == '0) begin
								mode_n = M_OPCODE;
							end
						end
					end else if (mode_q != M_WAITING) begin
						off_n = off_q + OFF_W'(1);
						case (mode_q)
							M_OPCODE: begin
								if (item.stream_byte == OP_WRITE_REG) begin
									mode_n = M_ADDR;
								end else if (item.stream_byte == OP_WAIT) begin
									mode_n = M_WAITBYTES;
									fcnt_n = '0;
									asm_n  = '0;
								end else if (item.stream_byte == OP_END) begin
									if (loop_enable) begin
										mode_n = M_LOOPBYTES;
										fcnt_n = '0;
										asm_n  = '0;
									end else begin
										mode_n = M_STOPPED;
										is_sil = 1'b1;
									end
								end else begin
									mode_n        = M_ERROR;
									res.event_res = EV_BAD;
								end
							end
							M_ADDR: begin
								haddr_n = item.stream_byte;
								mode_n  = M_DATA;
							end
							M_DATA: begin
								mode_n        = M_OPCODE;
								res.event_res = EV_WRITE;
								res.reg_addr  = haddr_q;
								res.reg_data  = item.stream_byte;
							end
							default: begin
								asm_n = asm_or;
								if (fcnt_q != 2'd3) begin
									fcnt_n = fcnt_q + 2'd1;
								end else begin
									fcnt_n = '0;
									if (mode_q == M_WAITBYTES) begin
										wait_n          = WAIT_W'(lo_part) + {1'b0, hi_part, 16'h0000};
										mode_n          = M_WAITING;
										res.event_res   = EV_WAIT;
										res.wait_cycles = WAIT_W'(lo_part) + {1'b0, hi_part, 16'h0000};
									end else begin
										off_n         = asm_or;
										mode_n        = M_OPCODE;
										res.event_res = EV_LOOP;
									end
								end
							end
						endcase
					end
				end
			endcase
			if (is_sil) begin
				res.event_res   = EV_WRITE;
				res.reg_addr    = silence_addr('0);
				res.reg_data    = silence_data('0);
				res.last_of_run = 1'b0;
			end
		end
		res.play_offset = off_n;
		res.want_byte   = (mode_n inside {[M_OPCODE:M_LOOPBYTES]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_STOPPED;
			fcnt_q  <= '0;
			haddr_q <= '0;
			asm_q   <= '0;
			wait_q  <= '0;
			off_q   <= '0;
			run_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (emit) begin
			if (run_q) begin
				if (sil_last) begin
					run_q <= 1'b0;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + SIL_IDX_W'(1);
				end
			end else begin
				mode_q  <= mode_n;
				fcnt_q  <= fcnt_n;
				haddr_q <= haddr_n;
				asm_q   <= asm_n;
				wait_q  <= wait_n;
				off_q   <= off_n;
				if (is_sil) begin
					run_q <= 1'b1;
					cnt_q <= SIL_IDX_W'(1);
				end
			end
		end
	end

endmodule

/* rtl/srsp_out_stage.sv */
// Result register driving the output stream.
module srsp_out_stage (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               emit,
	input  srsp_pkg::result_t                  res,
	output logic                               slot_free,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [srsp_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic [2:0]                         m_tuser,
	output logic                               m_tlast
);
	import srsp_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign slot_free = !valid_q || m_tready;
	assign m_tvalid  = valid_q;
	assign m_tuser   = res_q.event_res;
	assign m_tlast   = res_q.last_of_run;
	assign m_tdata   = {6'b000000, res_q.want_byte, res_q.play_offset,
		res_q.wait_cycles, res_q.reg_data, res_q.reg_addr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res;
		end
	end

endmodule

/* rtl/sound_register_stream_player.sv */
// Top level of the sound register stream player.
//
// channel | signals                               | direction
// s       | s_tvalid s_tready s_tdata s_tuser     | in: command transactions
// m       | m_tvalid m_tready m_tdata m_tuser m_tlast | out: result transactions
// cfg     | cfg_valid cfg_ready cfg_data          | in: loop_enable write
//
// An item passes the input register and the parser into the result register.
// One item per cycle is sustained outside silencing runs and output stalls.
// Start, stop and a non-looping end each produce 36 results from the silencing table,
// one per cycle unless stalled; the input register holds the item until the last one.
// A stalled output holds its result while one more item waits in the input register.
// Reset clears the player to stopped with read offset zero and looping off.
module sound_register_stream_player #(
	parameter logic [7:0] OP_WRITE_REG = 8'd1,
	parameter logic [7:0] OP_WAIT      = 8'd2,
	parameter logic [7:0] OP_END       = 8'd3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // stream_byte
	input  logic [1:0]                      s_tuser,   // command
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// reg_addr, reg_data, wait_cycles, play_offset, want_byte, zero fill
	output logic [srsp_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [2:0]                      m_tuser,   // event_res
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_data
);
	import srsp_pkg::*;

	logic     loop_enable_q;
	logic     item_valid;
	in_item_t item;
	logic     consume;
	logic     emit;
	logic     slot_free;
	result_t  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			loop_enable_q <= cfg_data;
		end
	end

	srsp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.consume    (consume),
		.item_valid (item_valid),
		.item       (item)
	);

	srsp_engine #(
		.OP_WRITE_REG (OP_WRITE_REG),
		.OP_WAIT      (OP_WAIT),
		.OP_END       (OP_END)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.loop_enable (loop_enable_q),
		.item_valid  (item_valid),
		.item        (item),
		.slot_free   (slot_free),
		.emit        (emit),
		.consume     (consume),
		.res         (res)
	);

	srsp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.res       (res),
		.slot_free (slot_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

/* rtl/srsp_checker.sv */
// Port-level checks on the result stream of the stream player.
module srsp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [srsp_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [2:0]                      m_tuser,
	input logic                            m_tlast
);
	import srsp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_run_is_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == EV_WRITE)
		else $error("multi-result run carries a non-write event");

	a_wait_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != EV_WAIT |-> m_tdata[48:16] == '0)
		else $error("wait count set on a non-wait event");

	a_idle_no_want: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == EV_STOPPED || m_tuser == EV_BAD) |-> !m_tdata[81])
		else $error("byte requested while stopped or in error");

endmodule

bind sound_register_stream_player srsp_checker u_srsp_checker (.*);
